[rtl/cftic_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cftic_pkg;

  // default sizes
  localparam int TRACE_DEPTH_DEF   = 8;
  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int DUMP_LIMIT_DEF    = 8;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_TREAD  = 2'd1,
    OP_CREAD  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // bus in the top bits, then extended flag, then identifier
  typedef struct packed {
    logic [1:0]  bus;
    logic        ext;
    logic [28:0] id;
  } key_t;

  typedef struct packed {
    key_t        key;
    logic [31:0] hits;
    logic [31:0] last_ms;
  } entry_t;

  // update request applied on the way into a cell
  typedef struct packed {
    logic        hit;
    logic        wr_new;
    key_t        key;
    logic [31:0] stamp;
  } cell_ctl_t;

  typedef struct packed {
    logic [3:0] dlc;
    key_t       key;
  } trace_hdr_t;

  typedef struct packed {
    logic        entry_valid;
    logic [1:0]  out_bus;
    logic        out_extended;
    logic [28:0] out_id;
    logic [3:0]  out_dlc;
    logic [63:0] out_payload;
    logic [31:0] out_hits;
    logic [31:0] out_last_ms;
    logic [3:0]  trace_held;
    logic [4:0]  ids_held;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/cftic_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface cftic_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [1:0]  bus_number;
  logic        extended_flag;
  logic [28:0] frame_id;
  logic [3:0]  frame_dlc;
  logic [63:0] frame_payload;
  logic [31:0] now_ms;
  logic [3:0]  entry_index;

  modport source (
    output valid, opcode, bus_number, extended_flag, frame_id, frame_dlc,
           frame_payload, now_ms, entry_index,
    input  ready
  );

  modport sink (
    input  valid, opcode, bus_number, extended_flag, frame_id, frame_dlc,
           frame_payload, now_ms, entry_index,
    output ready
  );
endinterface

`default_nettype wire

[rtl/cftic_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface cftic_out_if;
  logic        valid;
  logic        ready;
  logic        entry_valid;
  logic [1:0]  out_bus;
  logic        out_extended;
  logic [28:0] out_id;
  logic [3:0]  out_dlc;
  logic [63:0] out_payload;
  logic [31:0] out_hits;
  logic [31:0] out_last_ms;
  logic [3:0]  trace_held;
  logic [4:0]  ids_held;

  modport source (
    output valid, entry_valid, out_bus, out_extended, out_id, out_dlc,
           out_payload, out_hits, out_last_ms, trace_held, ids_held,
    input  ready
  );

  modport sink (
    input  valid, entry_valid, out_bus, out_extended, out_id, out_dlc,
           out_payload, out_hits, out_last_ms, trace_held, ids_held,
    output ready
  );
endinterface

`default_nettype wire

[rtl/cftic_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module cftic_cell
  import cftic_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      shift_en,
  input  wire entry_t    d_in,
  input  wire cell_ctl_t ctl,
  output entry_t         q
);

  entry_t q_r;
  entry_t q_nxt;

  always_comb begin
    q_nxt = d_in;
    if (ctl.wr_new) begin
      q_nxt.key     = ctl.key;
      q_nxt.hits    = 32'd1;
      q_nxt.last_ms = ctl.stamp;
    end else if (ctl.hit) begin
      q_nxt.hits    = d_in.hits + 32'd1;
      q_nxt.last_ms = ctl.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

[rtl/cftic_trace.sv]
`timescale 1ns / 1ps
`default_nettype none

module cftic_trace
  import cftic_pkg::*;
#(
  parameter int DEPTH = TRACE_DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire trace_hdr_t    wr_hdr,
  input  wire logic [63:0]   wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output trace_hdr_t         rd_hdr,
  output logic [63:0]        rd_data
);

  typedef struct packed {
    trace_hdr_t  hdr;
    logic [63:0] data;
  } row_t;

  row_t mem [DEPTH];
  row_t rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= '{hdr: wr_hdr, data: wr_data};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  assign rd_hdr  = rd_r.hdr;
  assign rd_data = rd_r.data;

endmodule

`default_nettype wire

[rtl/can_frame_trace_and_id_counter_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// record and counter read: the accepting beat starts a table scan (ST_SCAN) over one full rotation,
//   then ST_FIN loads the result register and the input is ready again in ST_IDLE; the table scan sets the time
// trace read and clear: the accepting beat leads straight to ST_FIN, which loads the result register
// a result not yet taken holds the next item in its final state and the input waits
// rst_n synchronous active low: empties trace ring and id table, no result pending
// trace memory is not cleared; only entries written since the last clear are read
module can_frame_trace_and_id_counter_top
  import cftic_pkg::*;
#(
  parameter int TRACE_DEPTH   = TRACE_DEPTH_DEF,
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int DUMP_LIMIT    = DUMP_LIMIT_DEF
) (
  input wire logic    clk,
  input wire logic    rst_n,
  cftic_in_if.sink    in_ch,
  cftic_out_if.source out_ch
);

  localparam int CW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int FW  = $clog2(TABLE_ENTRIES + 1);
  localparam int AW  = $clog2(TRACE_DEPTH);
  localparam int TFW = $clog2(TRACE_DEPTH + 1);
  localparam int DLW = $clog2(DUMP_LIMIT + 1);
  localparam int MW1 = (TFW > FW) ? TFW : FW;
  localparam int MW2 = (MW1 > DLW) ? MW1 : DLW;
  // wide enough for write pos + depth + index and every count compare
  localparam int SW  = MW2 + 5;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // latched request
  op_t         op_r;
  key_t        key_r;
  logic [31:0] now_r;
  logic [3:0]  idx_r;
  logic        trc_ok_r;

  // trace ring bookkeeping
  logic [AW-1:0]  wp_r;
  logic [TFW-1:0] trace_fill_r;

  // id table bookkeeping
  logic [FW-1:0] table_fill_r;
  logic [CW-1:0] cnt_r;
  logic          found_r;
  entry_t        cap_r;

  out_item_t out_r;
  logic      out_valid_r;

  wire logic in_beat  = in_ch.valid && in_ch.ready;
  wire logic out_free = !out_valid_r || out_ch.ready;
  wire op_t  in_op    = op_t'(in_ch.opcode);
  wire logic scan     = (state_r == ST_SCAN);
  wire logic last_cnt = (cnt_r == CW'(TABLE_ENTRIES - 1));

  key_t in_key;
  assign in_key = '{bus: in_ch.bus_number, ext: in_ch.extended_flag, id: in_ch.frame_id};

  // ---------------------------------------------------------------------------
  // trace read address: oldest of the shown frames sits at wp - shown
  // ---------------------------------------------------------------------------
  logic [SW-1:0] shown;
  logic [SW-1:0] src_sum;
  logic [SW-1:0] src_wrap;
  logic          trc_ok;

  always_comb begin
    shown = SW'(trace_fill_r);
    if (shown > SW'(DUMP_LIMIT)) begin
      shown = SW'(DUMP_LIMIT);
    end
    trc_ok   = SW'(in_ch.entry_index) < shown;
    src_sum  = SW'(wp_r) + SW'(TRACE_DEPTH) - shown + SW'(in_ch.entry_index);
    src_wrap = (src_sum >= SW'(TRACE_DEPTH)) ? (src_sum - SW'(TRACE_DEPTH)) : src_sum;
  end

  trace_hdr_t  rd_hdr;
  logic [63:0] rd_data;
  trace_hdr_t  wr_hdr;
  assign wr_hdr = '{dlc: in_ch.frame_dlc, key: in_key};

  cftic_trace #(
    .DEPTH (TRACE_DEPTH)
  ) u_trace (
    .clk     (clk),
    .wr_en   (in_beat && (in_op == OP_RECORD)),
    .wr_addr (wp_r),
    .wr_hdr  (wr_hdr),
    .wr_data (in_ch.frame_payload),
    .rd_en   (in_beat && (in_op == OP_TREAD) && trc_ok),
    .rd_addr (src_wrap[AW-1:0]),
    .rd_hdr  (rd_hdr),
    .rd_data (rd_data)
  );

  // ---------------------------------------------------------------------------
  // id table: ring of cells, cell 0 is the head compared each scan cycle,
  // the head entry (possibly updated) re-enters at the tail
  // ---------------------------------------------------------------------------
  entry_t    ring_q [TABLE_ENTRIES];
  cell_ctl_t tail_ctl;

  wire logic head_live = SW'(cnt_r) < SW'(table_fill_r);
  wire logic head_hit  = scan && (op_r == OP_RECORD) && head_live && (ring_q[0].key == key_r);
  // every held entry has passed the head before the first free slot arrives
  wire logic head_new  = scan && (op_r == OP_RECORD) && !found_r &&
                         (SW'(cnt_r) == SW'(table_fill_r));

  assign tail_ctl = '{hit: head_hit, wr_new: head_new, key: key_r, stamp: now_r};

  for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
    cftic_cell u_cell (
      .clk      (clk),
      .shift_en (scan),
      .d_in     (ring_q[(gi + 1) % TABLE_ENTRIES]),
      .ctl      ((gi == TABLE_ENTRIES - 1) ? tail_ctl : cell_ctl_t'('0)),
      .q        (ring_q[gi])
    );
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          state_nxt = ((in_op == OP_RECORD) || (in_op == OP_CREAD)) ? ST_SCAN : ST_FIN;
        end
      end
      ST_SCAN: begin
        if (last_cnt) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ready while no item is in work, even with a result still waiting
  assign in_ch.ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      wp_r         <= '0;
      trace_fill_r <= '0;
      table_fill_r <= '0;
      cnt_r        <= '0;
      found_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_beat) begin
        found_r <= 1'b0;
        cnt_r   <= '0;
        case (in_op)
          OP_RECORD: begin
            wp_r <= (wp_r == AW'(TRACE_DEPTH - 1)) ? '0 : wp_r + AW'(1);
            if (trace_fill_r != TFW'(TRACE_DEPTH)) begin
              trace_fill_r <= trace_fill_r + TFW'(1);
            end
          end
          OP_CLEAR: begin
            wp_r         <= '0;
            trace_fill_r <= '0;
            table_fill_r <= '0;
          end
          default: ;
        endcase
      end else if (scan) begin
        cnt_r <= last_cnt ? '0 : cnt_r + CW'(1);
        // once matched or appended, the rest of the rotation leaves the table alone
        if (head_hit || head_new) begin
          found_r <= 1'b1;
        end
        if (head_new) begin
          table_fill_r <= table_fill_r + FW'(1);
        end
      end
    end
  end

  // request payload and counter capture
  always_ff @(posedge clk) begin
    if (in_beat) begin
      op_r     <= in_op;
      key_r    <= in_key;
      now_r    <= in_ch.now_ms;
      idx_r    <= in_ch.entry_index;
      trc_ok_r <= trc_ok;
    end
    if (scan && (op_r == OP_CREAD) && (SW'(cnt_r) == SW'(idx_r))) begin
      cap_r <= ring_q[0];
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  out_item_t res;

  always_comb begin
    res            = '0;
    res.trace_held = 4'(trace_fill_r);
    res.ids_held   = 5'(table_fill_r);
    case (op_r)
      OP_TREAD: begin
        if (trc_ok_r) begin
          res.entry_valid  = 1'b1;
          res.out_bus      = rd_hdr.key.bus;
          res.out_extended = rd_hdr.key.ext;
          res.out_id       = rd_hdr.key.id;
          res.out_dlc      = rd_hdr.dlc;
          res.out_payload  = rd_data;
        end
      end
      OP_CREAD: begin
        if (SW'(idx_r) < SW'(table_fill_r)) begin
          res.entry_valid  = 1'b1;
          res.out_bus      = cap_r.key.bus;
          res.out_extended = cap_r.key.ext;
          res.out_id       = cap_r.key.id;
          res.out_hits     = cap_r.hits;
          res.out_last_ms  = cap_r.last_ms;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_FIN) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_FIN) && out_free) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.entry_valid  = out_r.entry_valid;
  assign out_ch.out_bus      = out_r.out_bus;
  assign out_ch.out_extended = out_r.out_extended;
  assign out_ch.out_id       = out_r.out_id;
  assign out_ch.out_dlc      = out_r.out_dlc;
  assign out_ch.out_payload  = out_r.out_payload;
  assign out_ch.out_hits     = out_r.out_hits;
  assign out_ch.out_last_ms  = out_r.out_last_ms;
  assign out_ch.trace_held   = out_r.trace_held;
  assign out_ch.ids_held     = out_r.ids_held;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_table_bound: assert property (@(posedge clk) disable iff (!rst_n)
    table_fill_r <= FW'(TABLE_ENTRIES))
    else $error("id table fill beyond capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && (in_op == OP_CLEAR)) |=> (trace_fill_r == '0) && (table_fill_r == '0))
    else $error("clear left entries held");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (scan && last_cnt) |=> (state_r == ST_FIN) && (cnt_r == '0))
    else $error("table scan did not end after one rotation");

  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    !(head_hit && head_new))
    else $error("frame both matched and appended");

endmodule

`default_nettype wire

[sim/can_frame_trace_and_id_counter_top_tb.sv]
`timescale 1ns / 1ps

module can_frame_trace_and_id_counter_top_tb;
  import cftic_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int RANDOM_OPS   = 1750;
  localparam int KEY_POOL     = 24;
  localparam int MAX_PRINTS   = 50;
  // record and counter read take the longest trip through the id table ring
  localparam int SETTLE_CYCLES = TABLE_ENTRIES_DEF + 10;

  // one command as offered on the input channel, plus its lead-in gap and drain flag
  typedef struct {
    op_t         op;
    logic [1:0]  bus;
    logic        ext;
    logic [28:0] id;
    logic [3:0]  dlc;
    logic [63:0] payload;
    logic [31:0] now;
    logic [3:0]  idx;
    int unsigned gap;
    bit          drain;
  } frame_cmd_t;

  logic clk;
  logic rst_n;

  cftic_in_if  in_ch ();
  cftic_out_if out_ch ();

  can_frame_trace_and_id_counter_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // commands waiting to be driven, and replies the monitor should see next
  frame_cmd_t frame_cmds[$];
  out_item_t  expected_replies[$];

  // shadow copy of the monitor state
  trace_hdr_t  shadow_hdr[TRACE_DEPTH_DEF];
  logic [63:0] shadow_data[TRACE_DEPTH_DEF];
  int unsigned shadow_wpos = 0;
  int unsigned shadow_trace_fill = 0;
  key_t        shadow_key[TABLE_ENTRIES_DEF];
  logic [31:0] shadow_hits[TABLE_ENTRIES_DEF];
  logic [31:0] shadow_last_ms[TABLE_ENTRIES_DEF];
  int unsigned shadow_id_fill = 0;

  // beat and cycle counters, updated with nonblocking writes so any process reads a stable value
  int unsigned cmds_accepted = 0;
  int unsigned replies_seen = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  // receiver hold-off, counted down in its own process
  int unsigned hold_cnt = 0;
  int unsigned holds_done = 0;

  // driver and monitor scratch
  frame_cmd_t  cur_cmd;
  bit          gap_loaded = 0;
  int unsigned gap_left = 0;
  bit          in_beat;
  bit          launch;
  bit          out_beat;
  int unsigned stall_left = 0;
  out_item_t   got_reply;
  out_item_t   want_reply;

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic key_t fresh_key();
    key_t k;
    k.bus = 2'($urandom_range(0, 3));
    k.ext = 1'($urandom_range(0, 1));
    // standard ids mostly stay 11 bits wide, extended ids use all 29; now and then any id gets all 29
    k.id  = k.ext ? 29'($urandom) : 29'($urandom_range(0, 2047));
    if ($urandom_range(0, 9) == 0) k.id = 29'($urandom);
    return k;
  endfunction

  function automatic void push_cmd(op_t op, key_t k, logic [3:0] dlc, logic [63:0] payload,
                                   logic [31:0] now, logic [3:0] idx);
    frame_cmd_t c;
    c.op      = op;
    c.bus     = k.bus;
    c.ext     = k.ext;
    c.id      = k.id;
    c.dlc     = dlc;
    c.payload = payload;
    c.now     = now;
    c.idx     = idx;
    c.gap     = pick_gap();
    c.drain   = 1'b0;
    frame_cmds.push_back(c);
  endfunction

  // applies one command to the shadow state and returns the reply it causes
  function automatic out_item_t monitor_reply(input frame_cmd_t c);
    out_item_t   r;
    key_t        k;
    int unsigned shown;
    int unsigned src;
    bit          found;
    r     = '0;
    k.bus = c.bus;
    k.ext = c.ext;
    k.id  = c.id;
    case (c.op)
      OP_RECORD: begin
        shadow_hdr[shadow_wpos].dlc = c.dlc;
        shadow_hdr[shadow_wpos].key = k;
        shadow_data[shadow_wpos]    = c.payload;
        shadow_wpos = (shadow_wpos + 1) % TRACE_DEPTH_DEF;
        if (shadow_trace_fill < TRACE_DEPTH_DEF) shadow_trace_fill++;
        found = 1'b0;
        for (int i = 0; i < shadow_id_fill; i++) begin
          if (!found && shadow_key[i] == k) begin
            shadow_hits[i]    = shadow_hits[i] + 32'd1;
            shadow_last_ms[i] = c.now;
            found = 1'b1;
          end
        end
        // full table drops an unknown id silently
        if (!found && shadow_id_fill < TABLE_ENTRIES_DEF) begin
          shadow_key[shadow_id_fill]     = k;
          shadow_hits[shadow_id_fill]    = 32'd1;
          shadow_last_ms[shadow_id_fill] = c.now;
          shadow_id_fill++;
        end
      end
      OP_TREAD: begin
        shown = shadow_trace_fill;
        if (shown > DUMP_LIMIT_DEF) shown = DUMP_LIMIT_DEF;
        if (shown > TRACE_DEPTH_DEF) shown = TRACE_DEPTH_DEF;
        // index 0 is the oldest of the frames shown
        if (c.idx < shown) begin
          src = (shadow_wpos + TRACE_DEPTH_DEF - shown + c.idx) % TRACE_DEPTH_DEF;
          r.entry_valid  = 1'b1;
          r.out_bus      = shadow_hdr[src].key.bus;
          r.out_extended = shadow_hdr[src].key.ext;
          r.out_id       = shadow_hdr[src].key.id;
          r.out_dlc      = shadow_hdr[src].dlc;
          r.out_payload  = shadow_data[src];
        end
      end
      OP_CREAD: begin
        if (c.idx < shadow_id_fill) begin
          r.entry_valid  = 1'b1;
          r.out_bus      = shadow_key[c.idx].bus;
          r.out_extended = shadow_key[c.idx].ext;
          r.out_id       = shadow_key[c.idx].id;
          r.out_hits     = shadow_hits[c.idx];
          r.out_last_ms  = shadow_last_ms[c.idx];
        end
      end
      default: begin
        // clear: ring contents stay but become unreachable
        shadow_wpos       = 0;
        shadow_trace_fill = 0;
        shadow_id_fill    = 0;
        for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
          shadow_key[i]     = '0;
          shadow_hits[i]    = '0;
          shadow_last_ms[i] = '0;
        end
      end
    endcase
    r.trace_held = 4'(shadow_trace_fill);
    r.ids_held   = 5'(shadow_id_fill);
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatch_cnt < MAX_PRINTS)
      $display("[%0t] mismatch on %s: got %0h, expected %0h (reply %0d)",
               $realtime, what, got, want, replies_seen);
    mismatch_cnt++;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // known values on every input from time zero, then reset once
  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.opcode        = OP_RECORD;
    in_ch.bus_number    = '0;
    in_ch.extended_flag = 1'b0;
    in_ch.frame_id      = '0;
    in_ch.frame_dlc     = '0;
    in_ch.frame_payload = '0;
    in_ch.now_ms        = '0;
    in_ch.entry_index   = '0;
    out_ch.ready        = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
  end

  // command list: a directed opening, then random traffic
  initial begin
    key_t        pool[KEY_POOL];
    key_t        k;
    key_t        zero_key;
    key_t        max_key;
    key_t        mid_key;
    int unsigned r;
    int unsigned fill_burst;
    logic [31:0] tick;
    logic [3:0]  idx;

    zero_key = '0;
    max_key  = '1;
    mid_key.bus = 2'd1;
    mid_key.ext = 1'b0;
    mid_key.id  = 29'h7ff;

    // reads on an empty monitor, then extremes of every frame field
    push_cmd(OP_TREAD, zero_key, '0, '0, '0, 4'd0);
    push_cmd(OP_CREAD, zero_key, '0, '0, '0, 4'd0);
    push_cmd(OP_RECORD, zero_key, 4'd0, 64'h0, 32'h0, 4'd0);
    push_cmd(OP_RECORD, max_key, 4'd15, '1, '1, 4'd15);
    // same key again: counts as a hit, new time
    push_cmd(OP_RECORD, zero_key, 4'd3, 64'h0123_4567_89ab_cdef, 32'd5, 4'd0);
    push_cmd(OP_RECORD, mid_key, 4'd8, 64'ha5a5_5a5a_f00f_0ff0, 32'd100, 4'd0);
    // same id, other ext flag or other bus: separate table entries
    mid_key.ext = 1'b1;
    push_cmd(OP_RECORD, mid_key, 4'd8, 64'h1122_3344_5566_7788, 32'd101, 4'd0);
    mid_key.ext = 1'b0;
    mid_key.bus = 2'd2;
    push_cmd(OP_RECORD, mid_key, 4'd9, 64'hffee_ddcc_bbaa_9988, 32'd102, 4'd0);
    // trace reads: oldest, newest, just past the end, far past the end
    push_cmd(OP_TREAD, zero_key, '0, '0, '0, 4'd0);
    push_cmd(OP_TREAD, zero_key, '0, '0, '0, 4'd5);
    push_cmd(OP_TREAD, zero_key, '0, '0, '0, 4'd6);
    push_cmd(OP_TREAD, zero_key, '0, '0, '0, 4'd15);
    // counter reads, including out of range
    push_cmd(OP_CREAD, zero_key, '0, '0, '0, 4'd0);
    push_cmd(OP_CREAD, zero_key, '0, '0, '0, 4'd4);
    push_cmd(OP_CREAD, zero_key, '0, '0, '0, 4'd5);
    push_cmd(OP_CREAD, zero_key, '0, '0, '0, 4'd15);
    // clear, then reads see nothing, then one frame after the clear
    push_cmd(OP_CLEAR, zero_key, '0, '0, '0, 4'd0);
    push_cmd(OP_TREAD, zero_key, '0, '0, '0, 4'd0);
    push_cmd(OP_CREAD, zero_key, '0, '0, '0, 4'd0);
    mid_key.bus = 2'd3;
    mid_key.id  = 29'h55;
    push_cmd(OP_RECORD, mid_key, 4'd2, 64'h0000_0000_0000_beef, 32'd7, 4'd0);
    push_cmd(OP_TREAD, zero_key, '0, '0, '0, 4'd0);
    push_cmd(OP_CREAD, zero_key, '0, '0, '0, 4'd0);

    // random traffic drawn mostly from a pool of repeating ids so hits pile up;
    // the pool is larger than the table so the table fills between clears
    foreach (pool[i]) pool[i] = fresh_key();
    tick       = $urandom;
    fill_burst = 0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      r = $urandom_range(0, 999);
      if (fill_burst != 0 || r < 550) begin
        if (fill_burst != 0) begin
          k = fresh_key();
          fill_burst--;
        end else if ($urandom_range(0, 99) < 75) begin
          k = pool[$urandom_range(0, KEY_POOL - 1)];
        end else begin
          k = fresh_key();
        end
        // occasionally start a run of new ids to push the table to full
        if ($urandom_range(0, 99) < 2) fill_burst = $urandom_range(16, 20);
        tick = tick + 32'($urandom_range(0, 50));
        push_cmd(OP_RECORD, k, 4'($urandom_range(0, 15)), {$urandom, $urandom},
                 ($urandom_range(0, 9) == 0) ? 32'($urandom) : tick, 4'($urandom));
      end else if (r < 760) begin
        // mostly in range, sometimes past the end
        idx = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 7)) : 4'($urandom);
        k   = fresh_key();
        push_cmd(OP_TREAD, k, 4'($urandom), {$urandom, $urandom}, $urandom, idx);
      end else if (r < 985) begin
        k = fresh_key();
        push_cmd(OP_CREAD, k, 4'($urandom), {$urandom, $urandom}, $urandom,
                 4'($urandom_range(0, 15)));
      end else begin
        k = fresh_key();
        push_cmd(OP_CLEAR, k, 4'($urandom), {$urandom, $urandom}, $urandom, 4'($urandom));
        foreach (pool[i]) pool[i] = fresh_key();
      end
      // sender waits for every reply before these
      if (n == 0 || n == 700 || n == 1400) frame_cmds[$].drain = 1'b1;
      // a stretch with no sender gaps
      if (n >= 1000 && n < 1200) frame_cmds[$].gap = 0;
    end
  end

  // driver: presents the next command once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_loaded  = 1'b0;
      gap_left    = 0;
    end else begin
      in_beat = in_ch.valid && in_ch.ready;
      if (in_beat) begin
        expected_replies.push_back(monitor_reply(cur_cmd));
        cmds_accepted <= cmds_accepted + 1;
      end
      if (in_beat || !in_ch.valid) begin
        launch = 1'b0;
        if (frame_cmds.size() != 0) begin
          if (!gap_loaded) begin
            gap_left   = frame_cmds[0].gap;
            gap_loaded = 1'b1;
          end
          if (gap_left != 0) begin
            gap_left--;
          end else if (!frame_cmds[0].drain ||
                       cmds_accepted + in_beat == replies_seen + (out_ch.valid && out_ch.ready)) begin
            launch = 1'b1;
          end
        end
        if (launch) begin
          cur_cmd    = frame_cmds.pop_front();
          gap_loaded = 1'b0;
          in_ch.opcode        <= cur_cmd.op;
          in_ch.bus_number    <= cur_cmd.bus;
          in_ch.extended_flag <= cur_cmd.ext;
          in_ch.frame_id      <= cur_cmd.id;
          in_ch.frame_dlc     <= cur_cmd.dlc;
          in_ch.frame_payload <= cur_cmd.payload;
          in_ch.now_ms        <= cur_cmd.now;
          in_ch.entry_index   <= cur_cmd.idx;
          in_ch.valid         <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-offs while the sender keeps offering, so the block backs up
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (holds_done == 0 && cmds_accepted >= 400) begin
      hold_cnt   <= 300;
      holds_done <= 1;
    end else if (holds_done == 1 && cmds_accepted >= 1300) begin
      hold_cnt   <= 300;
      holds_done <= 2;
    end
  end

  // monitor: checks each reply beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   = 0;
    end else begin
      out_beat = out_ch.valid && out_ch.ready;
      if (out_beat) begin
        got_reply.entry_valid  = out_ch.entry_valid;
        got_reply.out_bus      = out_ch.out_bus;
        got_reply.out_extended = out_ch.out_extended;
        got_reply.out_id       = out_ch.out_id;
        got_reply.out_dlc      = out_ch.out_dlc;
        got_reply.out_payload  = out_ch.out_payload;
        got_reply.out_hits     = out_ch.out_hits;
        got_reply.out_last_ms  = out_ch.out_last_ms;
        got_reply.trace_held   = out_ch.trace_held;
        got_reply.ids_held     = out_ch.ids_held;
        if (expected_replies.size() == 0) begin
          note_mismatch("unexpected reply", got_reply.out_id, '0);
        end else begin
          want_reply = expected_replies.pop_front();
          if (got_reply.entry_valid !== want_reply.entry_valid)
            note_mismatch("entry_valid", got_reply.entry_valid, want_reply.entry_valid);
          if (got_reply.out_bus !== want_reply.out_bus)
            note_mismatch("out_bus", got_reply.out_bus, want_reply.out_bus);
          if (got_reply.out_extended !== want_reply.out_extended)
            note_mismatch("out_extended", got_reply.out_extended, want_reply.out_extended);
          if (got_reply.out_id !== want_reply.out_id)
            note_mismatch("out_id", got_reply.out_id, want_reply.out_id);
          if (got_reply.out_dlc !== want_reply.out_dlc)
            note_mismatch("out_dlc", got_reply.out_dlc, want_reply.out_dlc);
          if (got_reply.out_payload !== want_reply.out_payload)
            note_mismatch("out_payload", got_reply.out_payload, want_reply.out_payload);
          if (got_reply.out_hits !== want_reply.out_hits)
            note_mismatch("out_hits", got_reply.out_hits, want_reply.out_hits);
          if (got_reply.out_last_ms !== want_reply.out_last_ms)
            note_mismatch("out_last_ms", got_reply.out_last_ms, want_reply.out_last_ms);
          if (got_reply.trace_held !== want_reply.trace_held)
            note_mismatch("trace_held", got_reply.trace_held, want_reply.trace_held);
          if (got_reply.ids_held !== want_reply.ids_held)
            note_mismatch("ids_held", got_reply.ids_held, want_reply.ids_held);
        end
        replies_seen <= replies_seen + 1;
        // a stretch with the receiver always ready
        stall_left = (replies_seen >= 1500 && replies_seen < 1650) ? 0 : pick_gap();
      end
      if (hold_cnt != 0) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // end of run: all commands taken, all replies in, then a quiet spell
  initial begin
    @(posedge rst_n);
    do @(posedge clk);
    while (frame_cmds.size() != 0 || in_ch.valid || cmds_accepted != replies_seen);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_replies.size() != 0)
      note_mismatch("replies never seen", expected_replies.size(), '0);
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/cftic_pkg.sv
rtl/cftic_in_if.sv
rtl/cftic_out_if.sv
rtl/cftic_cell.sv
rtl/cftic_trace.sv
rtl/can_frame_trace_and_id_counter_top.sv
sim/can_frame_trace_and_id_counter_top_tb.sv
